// ===== rtl/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk with async reset rst_n.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define RC4_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RC4_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rc4_pkg.sv =====
// ============================================================================
// rc4_pkg
// Constants, types and the controller-to-datapath command bundle of the
// stream cipher.
// ============================================================================
package rc4_pkg;

    // key store geometry
    localparam int unsigned KEY_DEPTH = 256;
    localparam int unsigned KEY_CNT_W = $clog2(KEY_DEPTH + 1);
    localparam int unsigned KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    // permutation geometry
    localparam int unsigned PERM_DEPTH = 256;
    localparam int unsigned BYTE_W     = 8;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [KEY_CNT_W-1:0] key_cnt_t;
    typedef logic [KEY_AW-1:0]    key_addr_t;

    localparam key_cnt_t KEY_FULL = key_cnt_t'(KEY_DEPTH);
    localparam byte_t    LAST_STEP = byte_t'(PERM_DEPTH - 1);

    // item opcodes
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // permutation read address select
    typedef enum logic [2:0] {
        RD_HOLD       = 3'd0,
        RD_GEN_NEXT_I = 3'd1,
        RD_GEN_J_NEW  = 3'd2,
        RD_SUM_T      = 3'd3,
        RD_KS_N       = 3'd4,
        RD_KS_ACC     = 3'd5
    } rd_sel_t;

    // permutation write select
    typedef enum logic [2:0] {
        WR_NONE   = 3'd0,
        WR_GEN_I  = 3'd1,
        WR_GEN_J  = 3'd2,
        WR_KS_N   = 3'd3,
        WR_KS_ACC = 3'd4
    } wr_sel_t;

    // command bundle from controller to datapath
    typedef struct packed {
        logic    key_wr;        // store key byte if room
        logic    sched_start;   // latch key length, reset pointers and table
        logic    data_load;     // latch data byte, advance i
        logic    a_capture;     // capture read data into a
        logic    t_capture;     // capture sum index and second read data
        logic    gen_j_update;  // j += S[i]
        logic    acc_update;    // schedule accumulator step
        logic    ks_advance;    // schedule n and key position step
        logic    result_load;   // load output byte register
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
    } cmd_t;

endpackage

// ===== rtl/rc4_if.sv =====
// ============================================================================
// rc4_if
// Valid/ready channels for input items and result items.
// ============================================================================

// input item channel
interface rc4_item_if;
    logic          valid;
    logic          ready;
    logic          opcode;
    rc4_pkg::byte_t data_byte;
    logic          key_last;

    modport source (output valid, output opcode, output data_byte, output key_last,
                    input ready);
    modport sink   (input valid, input opcode, input data_byte, input key_last,
                    output ready);
endinterface

// result item channel
interface rc4_result_if;
    logic          valid;
    logic          ready;
    rc4_pkg::byte_t out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// ===== rtl/rc4_ram.sv =====
// ============================================================================
// rc4_ram
// Generic single-write, single-read RAM with registered read (old data on
// a same-address write).
// ============================================================================
module rc4_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                                             clk,
    input  logic                                             wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     wr_addr,
    input  logic [WIDTH-1:0]                                 wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     rd_addr,
    output logic [WIDTH-1:0]                                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rc4_ctrl.sv =====
// ============================================================================
// rc4_ctrl
// Controller: sequences key entry, the key schedule and keystream steps,
// and owns the handshakes of both channels.
// ============================================================================
`include "assert_macros.svh"

module rc4_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_opcode,
    input  logic          in_key_last,
    output logic          in_ready,
    input  logic          out_ready,
    output logic          out_valid,
    input  logic          sched_last,
    output rc4_pkg::cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_GEN_J     = 8'b0000_0010,
        ST_GEN_SWAP  = 8'b0000_0100,
        ST_GEN_OUT   = 8'b0000_1000,
        ST_KS_READ   = 8'b0001_0000,
        ST_KS_ACC    = 8'b0010_0000,
        ST_KS_WR_N   = 8'b0100_0000,
        ST_KS_WR_ACC = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_beat;
    logic   out_beat;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign in_beat   = in_valid && in_ready;
    assign out_beat  = out_valid_reg && out_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = rc4_pkg::RD_HOLD;
        cmd.wr_sel = rc4_pkg::WR_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.rd_sel = rc4_pkg::RD_GEN_NEXT_I;
                if (in_beat)
                begin
                    if (in_opcode == rc4_pkg::OP_DATA)
                    begin
                        cmd.data_load = 1'b1;
                        state_next    = ST_GEN_J;
                    end
                    else
                    begin
                        cmd.key_wr = 1'b1;
                        if (in_key_last)
                        begin
                            cmd.sched_start = 1'b1;
                            state_next      = ST_KS_READ;
                        end
                    end
                end
            end
            ST_GEN_J:
            begin
                cmd.a_capture    = 1'b1;
                cmd.gen_j_update = 1'b1;
                cmd.rd_sel       = rc4_pkg::RD_GEN_J_NEW;
                state_next       = ST_GEN_SWAP;
            end
            ST_GEN_SWAP:
            begin
                cmd.t_capture = 1'b1;
                cmd.wr_sel    = rc4_pkg::WR_GEN_I;
                cmd.rd_sel    = rc4_pkg::RD_SUM_T;
                state_next    = ST_GEN_OUT;
            end
            ST_GEN_OUT:
            begin
                cmd.wr_sel = rc4_pkg::WR_GEN_J;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_KS_READ:
            begin
                cmd.rd_sel = rc4_pkg::RD_KS_N;
                state_next = ST_KS_ACC;
            end
            ST_KS_ACC:
            begin
                cmd.a_capture  = 1'b1;
                cmd.acc_update = 1'b1;
                cmd.rd_sel     = rc4_pkg::RD_KS_ACC;
                state_next     = ST_KS_WR_N;
            end
            ST_KS_WR_N:
            begin
                cmd.wr_sel = rc4_pkg::WR_KS_N;
                state_next = ST_KS_WR_ACC;
            end
            ST_KS_WR_ACC:
            begin
                cmd.wr_sel     = rc4_pkg::WR_KS_ACC;
                cmd.ks_advance = 1'b1;
                state_next     = sched_last ? ST_IDLE : ST_KS_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_beat)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a result appears only after a keystream step
    `RC4_ASSERT_IMP(a_result_src, $rose(out_valid_reg), $past(state_reg == ST_GEN_OUT), "result without keystream step")
    // a last key byte starts the schedule
    `RC4_ASSERT_NXT(a_sched_go, in_beat && in_opcode == rc4_pkg::OP_KEY && in_key_last, state_reg == ST_KS_READ, "key schedule not started")
    // a data byte starts a keystream step
    `RC4_ASSERT_NXT(a_gen_go, in_beat && in_opcode == rc4_pkg::OP_DATA, state_reg == ST_GEN_J, "keystream step not started")
    // a free output register takes the result at once
    `RC4_ASSERT_NXT(a_gen_done, state_reg == ST_GEN_OUT && !out_valid_reg, out_valid_reg && state_reg == ST_IDLE, "result not delivered")

endmodule

// ===== rtl/rc4_datapath.sv =====
// ============================================================================
// rc4_datapath
// Datapath: permutation and key RAMs, generator and schedule pointers,
// swap sequencing by command, keystream XOR and output byte register.
// ============================================================================
module rc4_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  rc4_pkg::cmd_t  cmd,
    input  rc4_pkg::byte_t data_byte,
    output rc4_pkg::byte_t out_byte,
    output logic           sched_last
);

    // control registers
    rc4_pkg::byte_t    i_reg, i_next;
    rc4_pkg::byte_t    j_reg, j_next;
    rc4_pkg::byte_t    n_reg, n_next;
    rc4_pkg::byte_t    acc_reg, acc_next;
    rc4_pkg::key_addr_t kpos_reg, kpos_next;
    rc4_pkg::key_cnt_t key_len_reg, key_len_next;
    rc4_pkg::key_cnt_t key_count_reg, key_count_next;
    logic [rc4_pkg::PERM_DEPTH-1:0] perm_vld_reg, perm_vld_next;

    // payload registers
    rc4_pkg::byte_t a_reg;
    rc4_pkg::byte_t b_reg;
    rc4_pkg::byte_t t_reg;
    rc4_pkg::byte_t byte_reg;
    rc4_pkg::byte_t out_byte_reg;
    rc4_pkg::byte_t rd_addr_reg;
    logic           rd_vld_reg;

    // combinational
    rc4_pkg::byte_t    rd_addr;
    rc4_pkg::byte_t    ram_rd_data;
    rc4_pkg::byte_t    perm_rd;
    rc4_pkg::byte_t    key_rd_data;
    rc4_pkg::byte_t    j_sum;
    rc4_pkg::byte_t    t_sum;
    rc4_pkg::byte_t    acc_sum;
    rc4_pkg::byte_t    wr_addr;
    rc4_pkg::byte_t    wr_data;
    logic              wr_en;
    logic              key_room;
    logic              key_store_en;
    rc4_pkg::key_cnt_t key_count_inc;
    rc4_pkg::key_cnt_t kpos_inc;
    rc4_pkg::byte_t    ks_byte;

    // an entry never written since the last reset or schedule holds its index
    assign perm_rd = rd_vld_reg ? ram_rd_data : rd_addr_reg;

    assign j_sum   = j_reg + perm_rd;
    assign t_sum   = a_reg + perm_rd;
    assign acc_sum = acc_reg + key_rd_data + perm_rd;

    // permutation read address
    always_comb
    begin
        unique case (cmd.rd_sel)
            rc4_pkg::RD_GEN_NEXT_I: rd_addr = i_reg + rc4_pkg::byte_t'(1);
            rc4_pkg::RD_GEN_J_NEW:  rd_addr = j_sum;
            rc4_pkg::RD_SUM_T:      rd_addr = t_sum;
            rc4_pkg::RD_KS_N:       rd_addr = n_reg;
            rc4_pkg::RD_KS_ACC:     rd_addr = acc_sum;
            default:                rd_addr = rd_addr_reg;
        endcase
    end

    // permutation write port
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = i_reg;
        wr_data = perm_rd;
        unique case (cmd.wr_sel)
            rc4_pkg::WR_GEN_I:
            begin
                wr_addr = i_reg;
                wr_data = perm_rd;
            end
            rc4_pkg::WR_GEN_J:
            begin
                wr_addr = j_reg;
                wr_data = a_reg;
            end
            rc4_pkg::WR_KS_N:
            begin
                wr_addr = n_reg;
                wr_data = perm_rd;
            end
            rc4_pkg::WR_KS_ACC:
            begin
                wr_addr = acc_reg;
                wr_data = a_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (rc4_pkg::PERM_DEPTH)
    ) u_perm_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // key store
    assign key_room     = (key_count_reg < rc4_pkg::KEY_FULL);
    assign key_store_en = cmd.key_wr && key_room;

    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (rc4_pkg::KEY_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_store_en),
        .wr_addr (key_count_reg[rc4_pkg::KEY_AW-1:0]),
        .wr_data (data_byte),
        .rd_addr (kpos_reg),
        .rd_data (key_rd_data)
    );

    assign key_count_inc = key_room ? key_count_reg + rc4_pkg::key_cnt_t'(1) : key_count_reg;
    assign kpos_inc      = rc4_pkg::key_cnt_t'(kpos_reg) + rc4_pkg::key_cnt_t'(1);
    assign sched_last    = (n_reg == rc4_pkg::LAST_STEP);

    // swapped pair may alias the keystream index
    always_comb
    begin
        if (t_reg == j_reg)
        begin
            ks_byte = a_reg;
        end
        else if (t_reg == i_reg)
        begin
            ks_byte = b_reg;
        end
        else
        begin
            ks_byte = perm_rd;
        end
    end

    // next values of control registers
    always_comb
    begin
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        kpos_next      = kpos_reg;
        key_len_next   = key_len_reg;
        key_count_next = key_count_reg;
        perm_vld_next  = perm_vld_reg;

        if (cmd.key_wr)
        begin
            key_count_next = key_count_inc;
        end
        if (cmd.sched_start)
        begin
            key_len_next   = key_count_inc;
            key_count_next = '0;
            i_next         = '0;
            j_next         = '0;
            n_next         = '0;
            acc_next       = '0;
            kpos_next      = '0;
        end
        if (cmd.data_load)
        begin
            i_next = i_reg + rc4_pkg::byte_t'(1);
        end
        if (cmd.gen_j_update)
        begin
            j_next = j_sum;
        end
        if (cmd.acc_update)
        begin
            acc_next = acc_sum;
        end
        if (cmd.ks_advance)
        begin
            n_next    = n_reg + rc4_pkg::byte_t'(1);
            kpos_next = (kpos_inc >= key_len_reg) ? '0 : kpos_reg + rc4_pkg::key_addr_t'(1);
        end

        // valid bits: schedule restarts from identity
        if (cmd.sched_start)
        begin
            perm_vld_next = '0;
        end
        else if (wr_en)
        begin
            perm_vld_next[wr_addr] = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            acc_reg       <= '0;
            kpos_reg      <= '0;
            key_len_reg   <= '0;
            key_count_reg <= '0;
            perm_vld_reg  <= '0;
        end
        else
        begin
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            acc_reg       <= acc_next;
            kpos_reg      <= kpos_next;
            key_len_reg   <= key_len_next;
            key_count_reg <= key_count_next;
            perm_vld_reg  <= perm_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr;
        rd_vld_reg  <= perm_vld_reg[rd_addr];
        if (cmd.data_load)
        begin
            byte_reg <= data_byte;
        end
        if (cmd.a_capture)
        begin
            a_reg <= perm_rd;
        end
        if (cmd.t_capture)
        begin
            t_reg <= t_sum;
            b_reg <= perm_rd;
        end
        if (cmd.result_load)
        begin
            out_byte_reg <= byte_reg ^ ks_byte;
        end
    end

    assign out_byte = out_byte_reg;

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// ============================================================================
// rc4_stream_cipher
// Stream cipher top level: key entry with last-key mark, 256-step key
// schedule and byte-wise keystream XOR.
// ============================================================================
//
//  channel  | role | payload                         | beat
//  ---------+------+---------------------------------+---------------------
//  item     | sink | opcode, data_byte, key_last     | one key or data byte
//  result   | src  | out_byte                        | one ciphered byte
//
//  key byte: the last key byte adds the schedule
//    (256 steps over one permutation read port and one write port)
//  data byte: three dependent reads of the permutation RAM and two writes
//    through its single write port; a full output register stalls the step
//  reset: the permutation reads as identity through per-entry valid bits,
//    so no clearing pass; item ready is high as soon as reset is released
//  a one-deep output register takes the next item while a result waits
//
module rc4_stream_cipher (
    input  logic       clk,
    input  logic       rst_n,
    rc4_item_if.sink   item,
    rc4_result_if.source result
);

    rc4_pkg::cmd_t cmd;
    logic          sched_last;

    // sequencing and handshakes
    rc4_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (item.valid),
        .in_opcode   (item.opcode),
        .in_key_last (item.key_last),
        .in_ready    (item.ready),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .sched_last  (sched_last),
        .cmd         (cmd)
    );

    // tables, pointers and keystream
    rc4_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .data_byte  (item.data_byte),
        .out_byte   (result.out_byte),
        .sched_last (sched_last)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Checks the stream cipher end to end. Key and data beats go in through the
// item channel; a cycle-free cipher model predicts each output byte, and a
// monitor compares every result beat with the oldest prediction. Both sides
// idle at random, with one hold-off on the result side and one quiet burst.
// ============================================================================
module tb;

    localparam int unsigned PERM_N       = 256;
    localparam int unsigned RANDOM_BEATS = 1200;
    localparam int unsigned RX_HOLD_LEN  = 300;
    localparam int unsigned TAIL_CYCLES  = 1200;

    logic clk;
    logic rst_n;

    rc4_item_if   item_ch ();
    rc4_result_if result_ch ();

    rc4_stream_cipher uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // cipher state mirrored by the testbench
    rc4_pkg::byte_t perm_tbl [PERM_N];
    rc4_pkg::byte_t key_bytes [rc4_pkg::KEY_DEPTH];
    int unsigned    key_fill;
    rc4_pkg::byte_t ptr_i;
    rc4_pkg::byte_t ptr_j;

    // output bytes still owed by the block, oldest first
    rc4_pkg::byte_t pending_out [$];

    int unsigned err_count;
    bit          no_idle;
    bit          rx_hold_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("[rc4_stream_cipher] ERROR");
        $finish;
    end

    // key schedule over the first len stored bytes
    function automatic void key_schedule(input int unsigned len);
        rc4_pkg::byte_t acc;
        rc4_pkg::byte_t tmp;
        int unsigned    kpos;
        acc  = '0;
        kpos = 0;
        for (int n = 0; n < PERM_N; n++)
            perm_tbl[n] = rc4_pkg::byte_t'(n);
        for (int n = 0; n < PERM_N; n++)
        begin
            acc = acc + key_bytes[kpos] + perm_tbl[n];
            tmp = perm_tbl[n];
            perm_tbl[n] = perm_tbl[acc];
            perm_tbl[acc] = tmp;
            kpos++;
            if (kpos >= len)
                kpos = 0;
        end
        ptr_i = '0;
        ptr_j = '0;
    endfunction

    // one accepted beat: key entry or one keystream step
    function automatic void cipher_step(input logic op, input rc4_pkg::byte_t value,
                                        input logic last);
        rc4_pkg::byte_t tmp;
        rc4_pkg::byte_t idx;
        if (op == rc4_pkg::OP_KEY)
        begin
            if (key_fill < rc4_pkg::KEY_DEPTH)
            begin
                key_bytes[key_fill] = value;
                key_fill++;
            end
            if (last)
            begin
                key_schedule(key_fill);
                key_fill = 0;
            end
        end
        else
        begin
            ptr_i = ptr_i + 8'd1;
            ptr_j = ptr_j + perm_tbl[ptr_i];
            tmp = perm_tbl[ptr_i];
            perm_tbl[ptr_i] = perm_tbl[ptr_j];
            perm_tbl[ptr_j] = tmp;
            idx = perm_tbl[ptr_i] + perm_tbl[ptr_j];
            pending_out.push_back(value ^ perm_tbl[idx]);
        end
    endfunction

    // drive one item beat; entered and left at a falling edge
    task automatic send_beat(input logic op, input rc4_pkg::byte_t value, input logic last);
        while (!no_idle && $urandom_range(99) < 8)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= op;
        item_ch.data_byte <= value;
        item_ch.key_last  <= last;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        cipher_step(op, value, last);
        @(negedge clk);
    endtask

    // key of len random bytes, marked on the final one
    task automatic send_key(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            send_beat(rc4_pkg::OP_KEY, rc4_pkg::byte_t'($urandom), k == len - 1);
    endtask

    task automatic send_data(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            send_beat(rc4_pkg::OP_DATA, rc4_pkg::byte_t'($urandom), 1'b0);
    endtask

    // sender stops until every owed byte has come back
    task automatic wait_for_results();
        item_ch.valid <= 1'b0;
        while (pending_out.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // result side ready, with random idling and the long hold-off
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (RX_HOLD_LEN) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            result_ch.ready <= no_idle || ($urandom_range(99) >= 8);
        end
    end

    // compare each result beat with the oldest owed byte
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_out.size() == 0)
            begin
                $error("out_byte: no result expected, got %02h", result_ch.out_byte);
                err_count++;
            end
            else if (result_ch.out_byte !== pending_out[0])
            begin
                $error("out_byte mismatch: expected %02h, actual %02h",
                       pending_out[0], result_ch.out_byte);
                err_count++;
                void'(pending_out.pop_front());
            end
            else
                void'(pending_out.pop_front());
        end
    end

    // data before any key runs on the identity table; key_last on data is ignored
    task automatic test_no_key();
        send_beat(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        send_beat(rc4_pkg::OP_DATA, 8'hFF, 1'b1);
        send_beat(rc4_pkg::OP_DATA, 8'h5A, 1'b0);
        send_beat(rc4_pkg::OP_DATA, 8'hA5, 1'b1);
    endtask

    // one-byte keys at the extremes, and data cut into a key entry
    task automatic test_short_keys();
        send_beat(rc4_pkg::OP_KEY, 8'h00, 1'b1);
        send_beat(rc4_pkg::OP_DATA, 8'hFF, 1'b0);
        send_beat(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        send_beat(rc4_pkg::OP_KEY, 8'hFF, 1'b1);
        send_beat(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        send_beat(rc4_pkg::OP_DATA, 8'hFF, 1'b0);
        send_beat(rc4_pkg::OP_KEY, 8'h01, 1'b0);
        send_beat(rc4_pkg::OP_KEY, 8'h80, 1'b0);
        send_beat(rc4_pkg::OP_DATA, 8'h3C, 1'b1);
        send_beat(rc4_pkg::OP_KEY, 8'h7F, 1'b0);
        send_beat(rc4_pkg::OP_DATA, 8'hC3, 1'b0);
        send_beat(rc4_pkg::OP_KEY, 8'hFE, 1'b1);
        send_data(4);
    endtask

    // exactly full key, then an overlong one marked on an ignored byte
    task automatic test_long_keys();
        send_key(rc4_pkg::KEY_DEPTH);
        send_data(6);
        send_key(rc4_pkg::KEY_DEPTH + 44);
        send_data(6);
        wait_for_results();
    endtask

    // burst with no idling on either side
    task automatic test_burst();
        no_idle = 1'b1;
        send_key(16);
        send_data(200);
        no_idle = 1'b0;
    endtask

    // result side holds off while items keep coming, so the input stalls
    task automatic test_backpressure();
        rx_hold_req = 1'b1;
        send_data(40);
        wait_for_results();
    endtask

    // mostly key-then-data sequences, some noise and some broken keys
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned seq;
        int unsigned pick;
        int unsigned klen;
        int unsigned n;
        logic        op;
        sent = 0;
        seq  = 0;
        while (sent < RANDOM_BEATS)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                // well-formed: key of mixed length, then a data run
                klen = $urandom_range(99);
                if (klen < 82)
                    klen = $urandom_range(1, 16);
                else if (klen < 95)
                    klen = $urandom_range(17, 64);
                else
                    klen = $urandom_range(200, 300);
                send_key(klen);
                sent += (klen > rc4_pkg::KEY_DEPTH) ? rc4_pkg::KEY_DEPTH : klen;
                n = $urandom_range(1, 40);
                send_data(n);
                sent += n;
            end
            else if (pick < 90)
            begin
                // noise: any opcode, occasional marks
                n = $urandom_range(5, 15);
                for (int unsigned k = 0; k < n; k++)
                begin
                    op = $urandom_range(1);
                    send_beat(op, rc4_pkg::byte_t'($urandom), $urandom_range(4) == 0);
                end
                sent += n;
            end
            else
            begin
                // broken: key cut off by data, left unfinished
                n = $urandom_range(1, 8);
                for (int unsigned k = 0; k < n; k++)
                    send_beat(rc4_pkg::OP_KEY, rc4_pkg::byte_t'($urandom), 1'b0);
                send_data($urandom_range(1, 10));
                sent += n + 5;
            end
            seq++;
            if (seq == 10)
                wait_for_results();
        end
    endtask

    // stimulus
    initial
    begin
        err_count   = 0;
        no_idle     = 1'b0;
        rx_hold_req = 1'b0;
        key_fill    = 0;
        ptr_i       = '0;
        ptr_j       = '0;
        for (int n = 0; n < PERM_N; n++)
            perm_tbl[n] = rc4_pkg::byte_t'(n);
        for (int n = 0; n < rc4_pkg::KEY_DEPTH; n++)
            key_bytes[n] = '0;
        item_ch.valid     = 1'b0;
        item_ch.opcode    = rc4_pkg::OP_KEY;
        item_ch.data_byte = '0;
        item_ch.key_last  = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_no_key();
        test_short_keys();
        test_long_keys();
        test_burst();
        test_backpressure();
        test_random_traffic();

        // drain, then let any schedule still running finish
        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (err_count == 0 && pending_out.size() == 0)
            $display("[rc4_stream_cipher] OK");
        else
            $display("[rc4_stream_cipher] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rc4_pkg.sv
rtl/rc4_if.sv
rtl/rc4_ram.sv
rtl/rc4_ctrl.sv
rtl/rc4_datapath.sv
rtl/rc4_stream_cipher.sv
sim/tb.sv
